// ===== rtl/rmsq_pkg.sv =====
// Package for the RMS normalization block: payload types, register map, sizes.
// No dependencies.
package rmsq_pkg;

  localparam int MaxRowDefault = 64;

  typedef struct packed {
    logic signed [15:0] sample;
    logic signed [15:0] gain;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] norm_value;
    logic [7:0]         code;
    logic               last;
  } out_beat_t;

  localparam logic [2:0] RegRowLength  = 3'd0;
  localparam logic [2:0] RegEpsilon    = 3'd1;
  localparam logic [2:0] RegQuantEn    = 3'd2;
  localparam logic [2:0] RegInvScale   = 3'd3;
  localparam logic [2:0] RegZeroOffset = 3'd4;

  typedef struct packed {
    logic [6:0]        row_length;
    logic [31:0]       epsilon;
    logic              quant_enable;
    logic [23:0]       inv_scale;
    logic signed [8:0] zero_offset;
  } cfg_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic clear;      // Reset accumulator and count.
    logic accum;      // Store and accumulate an input beat.
    logic div_start;  // Begin mean division.
    logic div_step;
    logic m_load;     // Form mean plus epsilon and the 2^64-1 dividend.
    logic q_step;     // Reciprocal division step.
    logic sq_load;
    logic sq_step;
    logic rd;         // Read one buffered element.
    logic mul1;       // First product stage.
    logic mul2;       // Product by r, split in parts.
    logic mul3;
    logic quant;      // Quantization product.
    logic emit;       // Load output register.
  } cmd_t;

  typedef struct packed {
    logic row_done;   // Row will close with the beat being accepted.
    logic last_elem;  // Read pointer is at the last element.
  } sts_t;

endpackage

// ===== rtl/rmsq_datapath.sv =====
// Datapath: row buffers, square sum, serial divider and square root, output arithmetic.
// Depends on rmsq_pkg.
module rmsq_datapath #(
  parameter int MaxRow = rmsq_pkg::MaxRowDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rmsq_pkg::cmd_t      cmd,
  input  rmsq_pkg::cfg_t      cfg,
  input  rmsq_pkg::in_beat_t  in_beat,
  output rmsq_pkg::sts_t      sts,
  output rmsq_pkg::out_beat_t out_beat
);

  localparam int Aw = (MaxRow > 1) ? $clog2(MaxRow) : 1;
  localparam int Cw = $clog2(MaxRow + 1);

  logic [15:0] samp_mem [MaxRow];
  logic [15:0] gain_mem [MaxRow];
  logic [37:0] sum_r;
  logic [Cw-1:0] cnt_r, rptr_r;
  logic [Cw-1:0] eff_len, idx;

  always_comb begin
    if (cfg.row_length == 7'd0) begin
      eff_len = Cw'(1);
    end else if ({25'd0, cfg.row_length} > MaxRow) begin
      eff_len = Cw'(MaxRow);
    end else begin
      eff_len = Cw'(cfg.row_length);
    end
    idx = (cnt_r >= Cw'(MaxRow)) ? Cw'(MaxRow - 1) : cnt_r;
  end

  logic [15:0] ax;
  assign ax = in_beat.sample[15] ? 16'(-in_beat.sample) : in_beat.sample;

  assign sts.row_done  = (idx + Cw'(1)) >= eff_len;
  assign sts.last_elem = (rptr_r + Cw'(1)) == cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      samp_mem[idx[Aw-1:0]] <= in_beat.sample;
      gain_mem[idx[Aw-1:0]] <= in_beat.gain;
    end
  end

  // Shared restoring divider: dividend up to 64 bits, divisor up to 33 bits.
  logic [63:0] dq_r;
  logic [33:0] rem_r;
  logic [32:0] dvs_r;
  logic [34:0] trial;
  assign trial = {rem_r, dq_r[63]} - {2'b00, dvs_r};

  // Square root of a 64-bit value, two bits per step.
  logic [63:0] sv_r;
  logic [33:0] srem_r;
  logic [31:0] sroot_r;
  logic [35:0] strial;
  assign strial = {srem_r, sv_r[63:62]} - {2'b00, sroot_r, 2'b01};

  logic [31:0] r_r;
  logic        mzero_r;
  logic [33:0] m_sum;
  assign m_sum = {1'b0, dq_r[32:0]} + {2'b00, cfg.epsilon};

  logic [15:0] rs_r, rg_r;
  logic        neg_r, last_r, neg2_r, last2_r, last3_r;
  logic [31:0] prod_r;
  logic [47:0] plo_r;
  logic [47:0] phi_r;
  logic [64:0] mag_full;
  logic signed [15:0] y_r;
  logic        ylast_r;
  logic [39:0] qp_r;

  assign mag_full = {17'd0, plo_r} + {1'b0, phi_r, 16'd0} + (65'd1 << 35);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      cnt_r  <= '0;
      rptr_r <= '0;
    end else begin
      if (cmd.clear) begin
        sum_r  <= '0;
        cnt_r  <= '0;
      end else if (cmd.accum) begin
        sum_r <= sum_r + {6'd0, 32'(ax) * 32'(ax)};
        cnt_r <= idx + Cw'(1);
      end
      if (cmd.div_start) begin
        rptr_r <= '0;
      end else if (cmd.rd) begin
        rptr_r <= rptr_r + Cw'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dq_r  <= {26'd0, sum_r};
      rem_r <= '0;
      dvs_r <= 33'(cnt_r);
    end else if (cmd.m_load) begin
      mzero_r <= (m_sum == 34'd0);
      dq_r    <= '1;
      rem_r   <= '0;
      dvs_r   <= m_sum[32:0];
    end else if (cmd.div_step || cmd.q_step) begin
      if (!trial[34]) begin
        rem_r <= trial[33:0];
        dq_r  <= {dq_r[62:0], 1'b1};
      end else begin
        rem_r <= {rem_r[32:0], dq_r[63]};
        dq_r  <= {dq_r[62:0], 1'b0};
      end
    end
    if (cmd.sq_load) begin
      sv_r    <= dq_r;
      srem_r  <= '0;
      sroot_r <= '0;
    end else if (cmd.sq_step) begin
      sv_r <= {sv_r[61:0], 2'b00};
      if (!strial[35]) begin
        srem_r  <= strial[33:0];
        sroot_r <= {sroot_r[30:0], 1'b1};
      end else begin
        srem_r  <= {srem_r[31:0], sv_r[63:62]};
        sroot_r <= {sroot_r[30:0], 1'b0};
      end
    end
    r_r <= mzero_r ? 32'hFFFF_FFFF : sroot_r;
    if (cmd.rd) begin
      rs_r   <= samp_mem[rptr_r[Aw-1:0]];
      rg_r   <= gain_mem[rptr_r[Aw-1:0]];
      last_r <= sts.last_elem;
    end
    if (cmd.mul1) begin
      prod_r <= 32'(rs_r[15] ? 16'(-rs_r) : rs_r) * 32'(rg_r[15] ? 16'(-rg_r) : rg_r);
      neg_r  <= rs_r[15] ^ rg_r[15];
      last2_r <= last_r;
    end
    if (cmd.mul2) begin
      plo_r  <= {16'd0, prod_r} * {32'd0, r_r[15:0]};
      phi_r  <= {16'd0, prod_r} * {32'd0, r_r[31:16]};
      neg2_r <= neg_r;
      last3_r <= last2_r;
    end
    if (cmd.mul3) begin
      if (mag_full[64:36] == 29'd0) begin
        y_r <= '0;
      end else if (neg2_r) begin
        y_r <= (mag_full[64:36] > 29'd32768) ? -16'sd32768 : 16'(-mag_full[51:36]);
      end else begin
        y_r <= (mag_full[64:36] > 29'd32767) ? 16'sd32767 : 16'(mag_full[51:36]);
      end
      ylast_r <= last3_r;
    end
    if (cmd.quant) begin
      qp_r <= {24'd0, (y_r[15] ? 16'(-y_r) : 16'(y_r))} * {16'd0, cfg.inv_scale}
              + 40'd32768;
    end
  end

  logic signed [25:0] t_val, c_val;
  always_comb begin
    t_val = y_r[15] ? -26'(qp_r[39:16]) : 26'(qp_r[39:16]);
    c_val = t_val - 26'(cfg.zero_offset);
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_beat.norm_value <= y_r;
      out_beat.last       <= ylast_r;
      if (!cfg.quant_enable || c_val < 0) begin
        out_beat.code <= '0;
      end else if (c_val > 26'sd255) begin
        out_beat.code <= 8'd255;
      end else begin
        out_beat.code <= c_val[7:0];
      end
    end
  end

endmodule

// ===== rtl/rmsq_ctrl.sv =====
// Controller state machine sequencing accumulate, rsqrt and emit phases.
// Depends on rmsq_pkg.
module rmsq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  rmsq_pkg::sts_t sts,
  output rmsq_pkg::cmd_t cmd
);

  typedef enum logic [6:0] {
    S_ACC  = 7'b0000001,
    S_DIV  = 7'b0000010,
    S_RCP  = 7'b0000100,
    S_SQRT = 7'b0001000,
    S_RD   = 7'b0010000,
    S_PIPE = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       lastrd_r, lastrd_nxt;
  logic       ov_r, ov_nxt;
  logic       acc;

  assign in_stall  = (state_r != S_ACC);
  assign out_valid = ov_r;
  assign acc       = in_valid && (state_r == S_ACC);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    lastrd_nxt = lastrd_r;
    ov_nxt     = ov_r && out_stall;
    cmd        = '0;
    cmd.accum  = acc;
    unique case (state_r)
      S_ACC: begin
        if (acc && sts.row_done) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end
      end
      S_DIV: begin
        if (cnt_r == 7'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 7'd1;
        end else if (cnt_r <= 7'd64) begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
        end else begin
          cmd.m_load = 1'b1;
          cnt_nxt    = '0;
          state_nxt  = S_RCP;
        end
      end
      S_RCP: begin
        cmd.q_step = 1'b1;
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cnt_r == 7'd0) begin
          cmd.sq_load = 1'b1;
        end else begin
          cmd.sq_step = 1'b1;
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd32) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        lastrd_nxt = sts.last_elem;
        cnt_nxt    = '0;
        state_nxt  = S_PIPE;
      end
      S_PIPE: begin
        cnt_nxt = cnt_r + 7'd1;
        unique case (cnt_r)
          7'd0: cmd.mul1 = 1'b1;
          7'd1: cmd.mul2 = 1'b1;
          7'd2: cmd.mul3 = 1'b1;
          default: begin
            cmd.quant = 1'b1;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          cmd.emit  = 1'b1;
          cmd.clear = lastrd_r;
          ov_nxt    = 1'b1;
          state_nxt = lastrd_r ? S_ACC : S_RD;
        end
      end
      default: state_nxt = S_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_ACC;
      cnt_r    <= '0;
      lastrd_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      lastrd_r <= lastrd_nxt;
      ov_r     <= ov_nxt;
    end
  end

endmodule

// ===== rtl/rms_norm_affine_quantize.sv =====
// Top level of the RMS normalization and uint8 quantization block.
// Depends on rmsq_pkg, rmsq_ctrl and rmsq_datapath.
// Each input beat is taken without a stall while a row fills. When the row closes the
// block computes the reciprocal root through a shared one-bit-per-cycle divider
// (64 steps for the mean, 64 for the reciprocal) and a two-bits-per-cycle square
// root (32 steps), and then emits the row one element at a time, each read from the buffer
// and sent through the multiply pipeline before the next is read, while the output is not
// stalled; no input is taken until the last element of the row is in the output register.
module rms_norm_affine_quantize #(
  parameter int MaxRow = rmsq_pkg::MaxRowDefault
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rmsq_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rmsq_pkg::out_beat_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  rmsq_pkg::cfg_t cfg_r;
  rmsq_pkg::cmd_t cmd;
  rmsq_pkg::sts_t sts;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_length   <= 7'd64;
      cfg_r.epsilon      <= 32'd1;
      cfg_r.quant_enable <= 1'b0;
      cfg_r.inv_scale    <= 24'd256;
      cfg_r.zero_offset  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        rmsq_pkg::RegRowLength:  cfg_r.row_length   <= pwdata[6:0];
        rmsq_pkg::RegEpsilon:    cfg_r.epsilon      <= pwdata;
        rmsq_pkg::RegQuantEn:    cfg_r.quant_enable <= pwdata[0];
        rmsq_pkg::RegInvScale:   cfg_r.inv_scale    <= pwdata[23:0];
        rmsq_pkg::RegZeroOffset: cfg_r.zero_offset  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      rmsq_pkg::RegRowLength:  prdata = {25'd0, cfg_r.row_length};
      rmsq_pkg::RegEpsilon:    prdata = cfg_r.epsilon;
      rmsq_pkg::RegQuantEn:    prdata = {31'd0, cfg_r.quant_enable};
      rmsq_pkg::RegInvScale:   prdata = {8'd0, cfg_r.inv_scale};
      rmsq_pkg::RegZeroOffset: prdata = {{23{cfg_r.zero_offset[8]}}, cfg_r.zero_offset};
      default:                 prdata = '0;
    endcase
  end

  rmsq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  rmsq_datapath #(.MaxRow(MaxRow)) u_dp (
    .clk, .rst_n, .cmd, .cfg(cfg_r), .in_beat(in_data), .sts, .out_beat(out_data)
  );

endmodule

// ===== rtl/rmsq_checker.sv =====
// Port-level checker for the RMS normalization block, bound to the top level.
// Depends on rmsq_pkg.
module rmsq_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input rmsq_pkg::out_beat_t out_data,
  input logic                pready
);

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled output beat changed.");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("Result beat started right after an input beat.");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("Beat emitted after the last of a row.");

  assert property (@(posedge clk) pready)
    else $error("Config port not ready.");

endmodule

bind rms_norm_affine_quantize rmsq_checker u_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data, .pready
);
